@@ hdl/actr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actr_pkg
// Shared types, constants and byte functions of the AES-256 counter-mode core.
// ----------------------------------------------------------------------------
package actr_pkg;

    localparam int ROUNDS    = 14;
    localparam int RK_COUNT  = 15;
    localparam int BLOCK_B   = 16;
    localparam logic [4:0] COUNT_MAX = 5'd16;
    localparam logic [7:0] GF_POLY   = 8'h1b;
    localparam logic [7:0] RCON_INIT = 8'h01;

    // configuration register indexes
    localparam logic [2:0] REG_KEY0    = 3'd0;
    localparam logic [2:0] REG_KEY1    = 3'd1;
    localparam logic [2:0] REG_KEY2    = 3'd2;
    localparam logic [2:0] REG_KEY3    = 3'd3;
    localparam logic [2:0] REG_IV_HIGH = 3'd4;
    localparam logic [2:0] REG_IV_LOW  = 3'd5;

    typedef struct packed {
        logic        first_block;
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  byte_count;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  out_count;
    } out_beat_t;

    // one pipeline stage of the cipher
    typedef struct packed {
        logic [127:0] state;
        logic [63:0]  data_high;
        logic [63:0]  data_low;
        logic [4:0]   count;
    } pipe_t;

    // key expansion status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } ke_status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sub_byte(input logic [7:0] b);
        return SBOX[b];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

@@ hdl/actr_col.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actr_col
// One column lane of a cipher round: byte substitution, column mix and key add.
// ----------------------------------------------------------------------------
module actr_col #(
    parameter bit LAST = 1'b0
) (
    input  logic [31:0] col_in,
    input  logic [31:0] rk_word,
    output logic [31:0] col_out
);

    logic [7:0] a0, a1, a2, a3, all_x;
    logic [31:0] mixed;

    // substitute the four bytes
    assign a0 = actr_pkg::sub_byte(col_in[31:24]);
    assign a1 = actr_pkg::sub_byte(col_in[23:16]);
    assign a2 = actr_pkg::sub_byte(col_in[15:8]);
    assign a3 = actr_pkg::sub_byte(col_in[7:0]);
    assign all_x = a0 ^ a1 ^ a2 ^ a3;

    // column mix, skipped in the final round
    always_comb
    begin
        if (LAST)
        begin
            mixed = {a0, a1, a2, a3};
        end
        else
        begin
            mixed = {a0 ^ all_x ^ actr_pkg::gf_double(a0 ^ a1),
                     a1 ^ all_x ^ actr_pkg::gf_double(a1 ^ a2),
                     a2 ^ all_x ^ actr_pkg::gf_double(a2 ^ a3),
                     a3 ^ all_x ^ actr_pkg::gf_double(a3 ^ a0)};
        end
    end

    assign col_out = mixed ^ rk_word;

endmodule

@@ hdl/actr_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actr_round
// One registered cipher round: row shift and four column lanes side by side.
// ----------------------------------------------------------------------------
module actr_round #(
    parameter bit LAST = 1'b0
) (
    input  logic            clk,
    input  logic            load,
    input  actr_pkg::pipe_t stage_in,
    input  logic [127:0]    round_key,
    output actr_pkg::pipe_t stage_reg
);

    logic [127:0] shifted;
    logic [127:0] result;

    // row shift: byte i of column c comes from column (c + i) mod 4
    genvar c, i;
    generate
        for (c = 0; c < 4; c++)
        begin : g_shift
            for (i = 0; i < 4; i++)
            begin : g_byte
                assign shifted[127 - 8 * (i + 4 * c) -: 8] =
                    stage_in.state[127 - 8 * (i + 4 * ((c + i) % 4)) -: 8];
            end
        end
    endgenerate

    // column lanes
    generate
        for (c = 0; c < 4; c++)
        begin : g_lane
            actr_col #(
                .LAST (LAST)
            ) u_col (
                .col_in  (shifted[127 - 32 * c -: 32]),
                .rk_word (round_key[127 - 32 * c -: 32]),
                .col_out (result[127 - 32 * c -: 32])
            );
        end
    endgenerate

    // stage register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg.state     <= result;
            stage_reg.data_high <= stage_in.data_high;
            stage_reg.data_low  <= stage_in.data_low;
            stage_reg.count     <= stage_in.count;
        end
    end

endmodule

@@ hdl/actr_keyexp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actr_keyexp
// Iterative AES-256 key expansion, one 128-bit round key per cycle, and the
// round key store read by the cipher stages.
// ----------------------------------------------------------------------------
module actr_keyexp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [255:0]          key,
    output actr_pkg::ke_status_t  status,
    output logic [14:0][127:0]    rk_bus
);

    logic         busy_reg, busy_next;
    logic [3:0]   idx_reg, idx_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [127:0] prev2_reg, prev1_reg;
    logic [127:0] rk_reg [actr_pkg::RK_COUNT];
    logic [31:0]  t_word;
    logic [31:0]  n0, n1, n2, n3;
    logic [127:0] new_key;
    logic         last_step;

    // next round key from the two before it
    always_comb
    begin
        if (!idx_reg[0])
        begin
            t_word = actr_pkg::sub_word({prev1_reg[23:0], prev1_reg[31:24]}) ^
                     {rcon_reg, 24'h000000};
        end
        else
        begin
            t_word = actr_pkg::sub_word(prev1_reg[31:0]);
        end
        n0 = prev2_reg[127:96] ^ t_word;
        n1 = prev2_reg[95:64] ^ n0;
        n2 = prev2_reg[63:32] ^ n1;
        n3 = prev2_reg[31:0] ^ n2;
        new_key = {n0, n1, n2, n3};
    end

    assign last_step = busy_reg && (idx_reg == 4'(actr_pkg::ROUNDS));

    // sequencer control
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        rcon_next = rcon_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = 4'd2;
            rcon_next = actr_pkg::RCON_INIT;
        end
        else if (busy_reg)
        begin
            idx_next = idx_reg + 4'd1;
            if (!idx_reg[0])
            begin
                rcon_next = actr_pkg::gf_double(rcon_reg);
            end
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 4'd0;
            rcon_reg <= actr_pkg::RCON_INIT;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            rcon_reg <= rcon_next;
        end
    end

    // round key store and working keys
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rk_reg[0] <= key[255:128];
            rk_reg[1] <= key[127:0];
            prev2_reg <= key[255:128];
            prev1_reg <= key[127:0];
        end
        else if (busy_reg)
        begin
            rk_reg[idx_reg] <= new_key;
            prev2_reg       <= prev1_reg;
            prev1_reg       <= new_key;
        end
    end

    genvar r;
    generate
        for (r = 0; r < actr_pkg::RK_COUNT; r++)
        begin : g_out
            assign rk_bus[r] = rk_reg[r];
        end
    endgenerate

    assign status.busy = busy_reg;
    assign status.done = last_step;

endmodule

@@ hdl/aes256_ctr_cipher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_ctr_cipher
// AES-256 counter-mode cipher: fully pipelined rounds, four column lanes per
// round, keystream merged into the data beat in the output stage.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data   (actr_pkg::in_beat_t)
//   out      output     out_valid/ out_stall out_data  (actr_pkg::out_beat_t)
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// One beat per cycle while nothing stalls; stages: key add, 14 round stages, merge.
// A first block, or any block while no key is expanded, waits until the
// round stages drain and the key expansion has run, then enters.
// Reset clears the counter, the key-expanded flag and all stage valids.
// A stalled output holds its beat; inputs keep flowing into empty stages.
// ----------------------------------------------------------------------------
module aes256_ctr_cipher (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  actr_pkg::in_beat_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output actr_pkg::out_beat_t   out_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_wdata
);

    localparam int NSTG = actr_pkg::ROUNDS + 2;

    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg, ivh_reg, ivl_reg;
    logic [127:0] ctr_reg, ctr_next;
    logic         sched_valid_reg, fresh_reg;
    logic [NSTG-1:0] v_reg, v_next;
    logic [NSTG-1:0] free;
    logic [NSTG-1:0] load;
    logic         accept, need_exp, start, rounds_empty;
    logic [4:0]   sat_count;
    actr_pkg::ke_status_t ke;
    logic [14:0][127:0]   rks;
    actr_pkg::pipe_t      stage [actr_pkg::ROUNDS + 1];
    actr_pkg::pipe_t      stage0_reg;
    actr_pkg::pipe_t      s0_in;
    actr_pkg::out_beat_t  merged;
    actr_pkg::out_beat_t  out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
            ivh_reg  <= '0;
            ivl_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                actr_pkg::REG_KEY0:    key0_reg <= cfg_wdata;
                actr_pkg::REG_KEY1:    key1_reg <= cfg_wdata;
                actr_pkg::REG_KEY2:    key2_reg <= cfg_wdata;
                actr_pkg::REG_KEY3:    key3_reg <= cfg_wdata;
                actr_pkg::REG_IV_HIGH: ivh_reg  <= cfg_wdata;
                actr_pkg::REG_IV_LOW:  ivl_reg  <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    // key expansion unit
    actr_keyexp u_keyexp (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .key        ({key0_reg, key1_reg, key2_reg, key3_reg}),
        .status     (ke),
        .rk_bus     (rks)
    );

    // stage occupancy: a stage is free if empty or its beat moves on
    always_comb
    begin
        free[NSTG-1] = !v_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            free[k] = !v_reg[k] || free[k + 1];
        end
    end

    assign rounds_empty = (v_reg[NSTG-2:0] == '0);
    assign need_exp = in_data.first_block ? !fresh_reg : !sched_valid_reg;
    assign start    = in_valid && need_exp && !ke.busy && rounds_empty;
    assign in_stall = !free[0] || ke.busy || need_exp;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        load[0] = accept;
        for (int k = 1; k < NSTG; k++)
        begin
            load[k] = v_reg[k - 1] && free[k];
        end
        for (int k = 0; k < NSTG; k++)
        begin
            v_next[k] = free[k] ? load[k] : v_reg[k];
        end
    end

    // counter and key state: only a first block reloads the counter
    always_comb
    begin
        ctr_next = ctr_reg;
        if (start && in_data.first_block)
        begin
            ctr_next = {ivh_reg, ivl_reg};
        end
        else if (accept)
        begin
            ctr_next = ctr_reg + 128'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg         <= '0;
            sched_valid_reg <= 1'b0;
            fresh_reg       <= 1'b0;
            v_reg           <= '0;
        end
        else
        begin
            ctr_reg <= ctr_next;
            v_reg   <= v_next;
            if (ke.done)
            begin
                sched_valid_reg <= 1'b1;
                fresh_reg       <= 1'b1;
            end
            else if (accept)
            begin
                fresh_reg <= 1'b0;
            end
        end
    end

    // entry stage: initial key add
    assign sat_count = (in_data.byte_count > actr_pkg::COUNT_MAX) ?
                       actr_pkg::COUNT_MAX : in_data.byte_count;

    always_comb
    begin
        s0_in.state     = ctr_reg ^ rks[0];
        s0_in.data_high = in_data.data_high;
        s0_in.data_low  = in_data.data_low;
        s0_in.count     = sat_count;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            stage0_reg <= s0_in;
        end
    end

    assign stage[0] = stage0_reg;

    // round stages
    genvar r;
    generate
        for (r = 1; r <= actr_pkg::ROUNDS; r++)
        begin : g_round
            actr_round #(
                .LAST (r == actr_pkg::ROUNDS)
            ) u_round (
                .clk       (clk),
                .load      (load[r]),
                .stage_in  (stage[r - 1]),
                .round_key (rks[r]),
                .stage_reg (stage[r])
            );
        end
    endgenerate

    // merge stage: keystream into valid bytes, zero the rest
    always_comb
    begin
        logic [127:0] d;
        logic [127:0] m;
        d = {stage[actr_pkg::ROUNDS].data_high, stage[actr_pkg::ROUNDS].data_low} ^
            stage[actr_pkg::ROUNDS].state;
        for (int b = 0; b < actr_pkg::BLOCK_B; b++)
        begin
            m[127 - 8 * b -: 8] = (5'(b) < stage[actr_pkg::ROUNDS].count) ?
                                  d[127 - 8 * b -: 8] : 8'h00;
        end
        merged.out_high  = m[127:64];
        merged.out_low   = m[63:0];
        merged.out_count = stage[actr_pkg::ROUNDS].count;
    end

    always_ff @(posedge clk)
    begin
        if (load[NSTG-1])
        begin
            out_reg <= merged;
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_data  = out_reg;

    // checks
    a_no_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        ke.busy |-> !accept)
        else $error("beat accepted during key expansion");

    a_accept_keyed : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> sched_valid_reg)
        else $error("beat accepted without expanded key");

    a_start_drained : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> rounds_empty)
        else $error("key expansion started with rounds in flight");

    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.out_count <= actr_pkg::COUNT_MAX))
        else $error("output count above block size");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the AES-256 counter-mode cipher. A built-in AES-256
// keystream predictor tracks counter and key schedule; a small scoreboard
// compares every output beat in order. Random idling on both channels, a long
// output hold-off and a full drain exercise the pipeline and its stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG = 20000;

    // scoreboard: ordered expected output beats
    class ctr_scoreboard;
        actr_pkg::out_beat_t pending[$];
        int                  mismatches;

        function void note_block(actr_pkg::out_beat_t exp_beat);
            pending.push_back(exp_beat);
        endfunction

        function void check_beat(actr_pkg::out_beat_t got);
            actr_pkg::out_beat_t exp_beat;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %h %h %0d", got.out_high, got.out_low,
                             got.out_count);
                return;
            end
            exp_beat = pending.pop_front();
            if (got !== exp_beat)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat mismatch: exp %h %h %0d got %h %h %0d",
                             exp_beat.out_high, exp_beat.out_low, exp_beat.out_count,
                             got.out_high, got.out_low, got.out_count);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    actr_pkg::in_beat_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    actr_pkg::out_beat_t out_data;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = actr_pkg::REG_KEY0;
    logic [63:0]         cfg_wdata = '0;

    aes256_ctr_cipher uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [63:0]  key_regs [4];
    logic [127:0] iv_reg;
    logic [127:0] ctr_value;
    logic [127:0] sched_keys [15];
    logic         keys_ready;

    ctr_scoreboard sb = new();
    int  idle_cycles;
    bit  quiet;
    bit  hold_out;
    int  hold_len;
    bit  timed_out;

    function automatic logic [7:0] xtime(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(logic [31:0] w);
        return {actr_pkg::SBOX[w[31:24]], actr_pkg::SBOX[w[23:16]],
                actr_pkg::SBOX[w[15:8]], actr_pkg::SBOX[w[7:0]]};
    endfunction

    // full AES-256 key schedule into sched_keys
    function automatic void expand_schedule();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
        begin
            w[2*i]   = key_regs[i][63:32];
            w[2*i+1] = key_regs[i][31:0];
        end
        for (int i = 8; i < 60; i++)
        begin
            t = w[i-1];
            if (i % 8 == 0)
            begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = xtime(rc);
            end
            else if (i % 8 == 4)
                t = sbox_word(t);
            w[i] = w[i-8] ^ t;
        end
        for (int r = 0; r < 15; r++)
            sched_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        keys_ready = 1'b1;
    endfunction

    // encrypt one counter block; byte 0 is bits 127:120
    function automatic logic [127:0] encrypt_counter(logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
            s[i] = blk[127-8*i -: 8] ^ sched_keys[0][127-8*i -: 8];
        for (int r = 1; r <= 14; r++)
        begin
            for (int i = 0; i < 16; i++)
                s[i] = actr_pkg::SBOX[s[i]];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[i+4*c] = s[i + 4*((c+i) % 4)];
            s = t;
            if (r < 14)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    s[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                    s[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                    s[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                    s[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
                end
            for (int i = 0; i < 16; i++)
                s[i] ^= sched_keys[r][127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++)
            res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    // expected output for one accepted input beat
    function automatic actr_pkg::out_beat_t predict_block(actr_pkg::in_beat_t b);
        logic [4:0]          n;
        logic [127:0]        ks, d, r;
        actr_pkg::out_beat_t o;
        n = (b.byte_count > 5'd16) ? 5'd16 : b.byte_count;
        if (b.first_block)
        begin
            ctr_value = iv_reg;
            expand_schedule();
        end
        else if (!keys_ready)
            expand_schedule();
        ks = encrypt_counter(ctr_value);
        d = {b.data_high, b.data_low} ^ ks;
        for (int i = 0; i < 16; i++)
            r[127-8*i -: 8] = (i < n) ? d[127-8*i -: 8] : 8'h00;
        ctr_value = ctr_value + 128'd1;
        o.out_high = r[127:64];
        o.out_low = r[63:0];
        o.out_count = n;
        return o;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            actr_pkg::REG_KEY0: key_regs[0] = val;
            actr_pkg::REG_KEY1: key_regs[1] = val;
            actr_pkg::REG_KEY2: key_regs[2] = val;
            actr_pkg::REG_KEY3: key_regs[3] = val;
            actr_pkg::REG_IV_HIGH: iv_reg[127:64] = val;
            actr_pkg::REG_IV_LOW: iv_reg[63:0] = val;
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // send one beat; optional idle burst first, valid held until accepted
    task automatic send_block(bit first, logic [63:0] dh, logic [63:0] dl, logic [4:0] cnt);
        actr_pkg::in_beat_t b;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        b.first_block = first;
        b.data_high = dh;
        b.data_low = dl;
        b.byte_count = cnt;
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_block(predict_block(b));
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic random_block(bit first);
        logic [4:0] cnt;
        case ($urandom_range(0, 5))
            0: cnt = 5'($urandom_range(0, 31));
            1: cnt = 5'($urandom_range(1, 15));
            default: cnt = 5'd16;
        endcase
        send_block(first, rand64(), rand64(), cnt);
    endtask

    // output side: random stall bursts, plus one long forced hold-off
    always @(negedge clk)
    begin
        if (hold_out)
        begin
            out_stall <= 1'b1;
            hold_len <= hold_len + 1;
            if (hold_len >= 150)
                hold_out <= 1'b0;
        end
        else if (!quiet && idle_cycles == 0 && $urandom_range(0, 9) == 0)
        begin
            idle_cycles <= $urandom_range(1, 19);
            out_stall <= 1'b1;
        end
        else if (idle_cycles > 1)
            idle_cycles <= idle_cycles - 1;
        else
        begin
            idle_cycles <= 0;
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
        if (out_valid && !out_stall)
            sb.check_beat(out_data);

    // watchdog on cycles with no accepted beat
    int stuck;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= WATCHDOG)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        quiet = 0;
        hold_out = 0;
        hold_len = 0;
        idle_cycles = 0;
        keys_ready = 1'b0;
        ctr_value = '0;
        iv_reg = '0;
        for (int i = 0; i < 4; i++)
            key_regs[i] = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: all-zero key, implicit expansion without first block
        send_block(1'b0, '0, '0, 5'd16);
        send_block(1'b0, '1, '1, 5'd16);
        send_block(1'b0, '1, '1, 5'd0);
        send_block(1'b0, '1, '1, 5'd31);
        send_block(1'b0, '1, '1, 5'd17);
        send_block(1'b0, '1, '1, 5'd1);
        send_block(1'b0, '1, '1, 5'd8);
        send_block(1'b0, '1, '1, 5'd9);
        drain();

        // all-ones key, counter near the wrap point
        write_reg(actr_pkg::REG_KEY0, '1);
        write_reg(actr_pkg::REG_KEY1, '1);
        write_reg(actr_pkg::REG_KEY2, '1);
        write_reg(actr_pkg::REG_KEY3, '1);
        write_reg(actr_pkg::REG_IV_HIGH, '1);
        write_reg(actr_pkg::REG_IV_LOW, 64'hffff_ffff_ffff_fffe);
        send_block(1'b1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd16);
        send_block(1'b0, '0, '0, 5'd16);
        send_block(1'b0, '0, '0, 5'd15);
        drain();

        // key changed mid-stream: takes effect only at the next first block
        write_reg(actr_pkg::REG_KEY1, 64'h0001_0203_0405_0607);
        write_reg(actr_pkg::REG_IV_HIGH, '0);
        write_reg(actr_pkg::REG_IV_LOW, '1);
        send_block(1'b0, '1, '0, 5'd16);
        send_block(1'b1, '1, '0, 5'd16);
        send_block(1'b0, '0, '1, 5'd16);
        drain();

        // random phases with new key and iv each time
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int k = 0; k < 6; k++)
                write_reg(k[2:0], rand64());
            for (int i = 0; i < 130; i++)
            begin
                if (ph == 2 && i == 10)
                begin
                    hold_len = 0;
                    hold_out = 1;
                end
                random_block(i == 0 || $urandom_range(0, 40) == 0);
            end
            drain();
        end

        // last stretch with no idling
        quiet = 1;
        for (int i = 0; i < 150; i++)
            random_block(i == 0);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
